// ===== rtl/core/rvex_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_pkg
// Opcodes, minor codes, status codes and the structs shared by the RV32I
// execute unit modules.
// ----------------------------------------------------------------------------
package rvex_pkg;

  localparam int NREGS  = 32;
  localparam int RIDX_W = 5;

  // major opcodes
  localparam logic [6:0] OP_R      = 7'h33;
  localparam logic [6:0] OP_I      = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;

  localparam logic [6:0] F7_ALT = 7'h20;

  // ALU minor codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // load / store minor codes
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  // branch minor codes
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // access sizes
  localparam logic [1:0] SZ_B = 2'd0;
  localparam logic [1:0] SZ_H = 2'd1;
  localparam logic [1:0] SZ_W = 2'd2;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_BAD_F3 = 2'd2;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [31:0]       data;
  } rvex_rf_wr_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] data;
  } rvex_mem_req_t;

  typedef struct packed {
    logic [31:0] val;
    logic        wr;
    logic [31:0] npc;
    logic        taken;
    logic [1:0]  status;
    logic        mem_rd;
    logic        mem_wr;
    logic [1:0]  size;
    logic [31:0] addr;
  } rvex_exec_t;

endpackage
`default_nettype wire

// ===== rtl/core/rvex_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_if
// Valid/ready channels of the execute unit: instruction in, result out.
// ----------------------------------------------------------------------------
interface rvex_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  op;
  logic [2:0]  funct3;
  logic [6:0]  funct7;
  logic [4:0]  src1_index;
  logic [4:0]  src2_index;
  logic [4:0]  dest_index;
  logic signed [31:0] immediate;
  logic [31:0] inst_pc;

  modport source (
    output valid, op, funct3, funct7, src1_index, src2_index, dest_index,
           immediate, inst_pc,
    input  ready
  );
  modport sink (
    input  valid, op, funct3, funct7, src1_index, src2_index, dest_index,
           immediate, inst_pc,
    output ready
  );
endinterface

interface rvex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        wrote_reg;
  logic [31:0] write_value;
  logic        branch_taken;
  logic [1:0]  status;

  modport source (
    output valid, next_pc, wrote_reg, write_value, branch_taken, status,
    input  ready
  );
  modport sink (
    input  valid, next_pc, wrote_reg, write_value, branch_taken, status,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/rvex_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rvex_regfile.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_regfile
// 32 x 32 register file: two RAM copies for two read ports, valid flags so
// that a register never written since reset reads zero. x0 is never written.
// ----------------------------------------------------------------------------
module rvex_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [rvex_pkg::RIDX_W-1:0] rd_idx1,
  input  wire logic [rvex_pkg::RIDX_W-1:0] rd_idx2,
  input  wire rvex_pkg::rvex_rf_wr_t      wr,
  output logic      [31:0]                rdata1,
  output logic      [31:0]                rdata2
);
  import rvex_pkg::*;

  logic [NREGS-1:0] vld;
  logic             v1;
  logic             v2;
  logic [31:0]      ram1;
  logic [31:0]      ram2;

  rvex_ram #(.WIDTH(32), .DEPTH(NREGS)) u_port1 (
    .clk(clk), .we(wr.en), .waddr(wr.idx), .wdata(wr.data),
    .re(rd_en), .raddr(rd_idx1), .rdata(ram1)
  );

  rvex_ram #(.WIDTH(32), .DEPTH(NREGS)) u_port2 (
    .clk(clk), .we(wr.en), .waddr(wr.idx), .wdata(wr.data),
    .re(rd_en), .raddr(rd_idx2), .rdata(ram2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.idx] <= 1'b1;
      end
      // sample with the RAM read so flag and data line up
      if (rd_en) begin
        v1 <= vld[rd_idx1];
        v2 <= vld[rd_idx2];
      end
    end
  end

  assign rdata1 = v1 ? ram1 : 32'd0;
  assign rdata2 = v2 ? ram2 : 32'd0;

endmodule
`default_nettype wire

// ===== rtl/core/rvex_dmem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_dmem
// Byte-addressed data memory as four byte-lane RAM banks. Any access of up
// to four bytes, aligned or not, touches each bank at most once. Sweeps all
// rows to zero after reset while busy is high.
// ----------------------------------------------------------------------------
module rvex_dmem #(
  parameter int MEM_BYTES = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rvex_pkg::rvex_mem_req_t req,
  output logic [31:0]                  rdata,
  output logic                         busy
);
  import rvex_pkg::*;

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = AW - 2;

  logic [RW-1:0] clr_row;
  logic [1:0]    lo;
  logic [1:0]    lo_q;
  logic [RW-1:0] row;
  logic [7:0]    bdat [4];

  assign lo  = req.addr[1:0];
  assign row = req.addr[AW-1:2];

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0]    k;
    logic [RW-1:0] brow;
    logic          ben;
    logic [7:0]    wbyte;
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;

    assign k     = 2'(j) - lo;
    // bytes below the start lane wrap into the next row
    assign brow  = row + RW'(lo > 2'(j));
    assign wbyte = 8'(req.data >> {k, 3'b000});

    always_comb begin
      case (req.size)
        SZ_B:    ben = (k == 2'd0);
        SZ_H:    ben = (k <= 2'd1);
        default: ben = 1'b1;
      endcase
    end

    assign we    = busy | (req.wr & ben);
    assign waddr = busy ? clr_row : brow;
    assign wdata = busy ? 8'd0 : wbyte;

    rvex_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
      .re(req.rd), .raddr(brow), .rdata(bdat[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + RW'(1);
      if (clr_row == RW'(ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      lo_q <= lo;
    end
  end

  // rotate lanes so byte k of the access sits at bits 8k
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdata[8*k +: 8] = bdat[2'(k) + lo_q];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rvex_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_alu
// Execute logic: ALU, branch test, next pc, memory address and status for
// one instruction with its source operands.
// ----------------------------------------------------------------------------
module rvex_alu (
  input  wire logic [6:0]               op,
  input  wire logic [2:0]               f3,
  input  wire logic [6:0]               f7,
  input  wire logic [rvex_pkg::RIDX_W-1:0] rd,
  input  wire logic [31:0]              a,
  input  wire logic [31:0]              b,
  input  wire logic [31:0]              imm,
  input  wire logic [31:0]              pc,
  output rvex_pkg::rvex_exec_t          ex
);
  import rvex_pkg::*;

  logic        alt;
  logic        is_r;
  logic [31:0] opb;
  logic [4:0]  sh;
  logic [31:0] alu_val;
  logic [31:0] pc4;
  logic [31:0] sum;
  logic        slt;
  logic        sltu;
  logic        br_lt;
  logic        br_ltu;
  logic [31:0] val;
  logic        wr;

  assign alt  = (f7 == F7_ALT);
  assign is_r = (op == OP_R);
  assign opb  = is_r ? b : imm;
  assign sh   = opb[4:0];
  assign pc4  = pc + 32'd4;
  assign sum  = a + imm;
  assign slt  = ($signed(a) < $signed(opb));
  assign sltu = (a < opb);
  // branches always compare the two registers
  assign br_lt  = ($signed(a) < $signed(b));
  assign br_ltu = (a < b);

  always_comb begin
    case (f3)
      F3_ADD:  alu_val = (is_r && alt) ? a - opb : a + opb;
      F3_SLL:  alu_val = a << sh;
      F3_SLT:  alu_val = {31'd0, slt};
      F3_SLTU: alu_val = {31'd0, sltu};
      F3_XOR:  alu_val = a ^ opb;
      F3_SR:   alu_val = alt ? 32'($signed(a) >>> sh) : a >> sh;
      F3_OR:   alu_val = a | opb;
      default: alu_val = a & opb;
    endcase
  end

  always_comb begin
    val       = 32'd0;
    wr        = 1'b0;
    ex.npc    = pc4;
    ex.taken  = 1'b0;
    ex.status = ST_OK;
    ex.mem_rd = 1'b0;
    ex.mem_wr = 1'b0;
    ex.size   = f3[1:0];
    ex.addr   = sum;
    case (op)
      OP_R, OP_I: begin
        val = alu_val;
        wr  = 1'b1;
      end
      OP_LOAD: begin
        if (f3 == F3_B || f3 == F3_H || f3 == F3_W || f3 == F3_BU || f3 == F3_HU) begin
          ex.mem_rd = 1'b1;
          wr        = 1'b1;
        end else begin
          ex.status = ST_BAD_F3;
        end
      end
      OP_STORE: begin
        if (f3 == F3_B || f3 == F3_H || f3 == F3_W) begin
          ex.mem_wr = 1'b1;
        end else begin
          ex.status = ST_BAD_F3;
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  ex.taken = (a == b);
          F3_BNE:  ex.taken = (a != b);
          F3_BLT:  ex.taken = br_lt;
          F3_BGE:  ex.taken = !br_lt;
          F3_BLTU: ex.taken = br_ltu;
          F3_BGEU: ex.taken = !br_ltu;
          default: ex.status = ST_BAD_F3;
        endcase
        if (ex.taken) begin
          ex.npc = pc + imm;
        end
      end
      OP_JAL: begin
        val    = pc4;
        wr     = 1'b1;
        ex.npc = pc + imm;
      end
      OP_JALR: begin
        val    = pc4;
        wr     = 1'b1;
        ex.npc = {sum[31:1], 1'b0};
      end
      OP_LUI: begin
        val = imm;
        wr  = 1'b1;
      end
      OP_AUIPC: begin
        val = pc + imm;
        wr  = 1'b1;
      end
      default: ex.status = ST_BAD_OP;
    endcase
    // drop writes to x0
    ex.wr  = wr && (rd != '0);
    ex.val = ex.wr ? val : 32'd0;
  end

endmodule
`default_nettype wire

// ===== rtl/core/rv32i_execute_unit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_execute_unit_top
// RV32I execute stage: register file and data memory in synchronous RAMs,
// three-stage read / execute / write-back pipeline with forwarding.
// ----------------------------------------------------------------------------
//  channel   role    handshake        payload
//  instr     sink    valid / ready    op funct3 funct7 src1/2 dest imm pc
//  result    source  valid / ready    next_pc wrote_reg write_value taken status
//
//  One instruction per cycle unless the result stalls or the memory
//  clear runs; from request to result: register file read, execute
//  plus data memory read, then write-back into the output register.
//  After reset the data memory is cleared one 4-byte row per cycle, with
//  instr.ready low. A stalled result holds the pipeline behind it; apart
//  from the clear, ready falls only when every stage is full and the
//  result is stalled.
// ----------------------------------------------------------------------------
module rv32i_execute_unit_top #(
  parameter int MEM_BYTES = 4096
) (
  input wire logic  clk,
  input wire logic  rst,
  rvex_in_if.sink   instr,
  rvex_out_if.source result
);
  import rvex_pkg::*;

  logic          busy;
  logic          in_acc;
  logic          s1_adv;
  logic          s2_adv;

  // read stage
  logic              s1_valid;
  logic [6:0]        s1_op;
  logic [2:0]        s1_f3;
  logic [6:0]        s1_f7;
  logic [RIDX_W-1:0] s1_rs1;
  logic [RIDX_W-1:0] s1_rs2;
  logic [RIDX_W-1:0] s1_rd;
  logic [31:0]       s1_imm;
  logic [31:0]       s1_pc;

  // memory / write-back stage
  logic              s2_valid;
  logic              s2_wr;
  logic              s2_load;
  logic [RIDX_W-1:0] s2_rd;
  logic [2:0]        s2_f3;
  logic [31:0]       s2_val;
  logic [31:0]       s2_npc;
  logic              s2_taken;
  logic [1:0]        s2_status;
  logic [31:0]       s2_result;

  logic [31:0]   rf_a;
  logic [31:0]   rf_b;
  logic [31:0]   opa;
  logic [31:0]   opb;
  logic [31:0]   ld_word;
  rvex_rf_wr_t   rf_wr;
  rvex_rf_wr_t   last_wr;
  rvex_mem_req_t mem_req;
  rvex_exec_t    ex;

  assign s2_adv      = s2_valid && (!result.valid || result.ready);
  assign s1_adv      = s1_valid && (!s2_valid || s2_adv);
  assign instr.ready = !busy && (!s1_valid || s1_adv);
  assign in_acc      = instr.valid && instr.ready;

  rvex_regfile u_regfile (
    .clk(clk), .rst(rst), .rd_en(in_acc),
    .rd_idx1(instr.src1_index), .rd_idx2(instr.src2_index),
    .wr(rf_wr), .rdata1(rf_a), .rdata2(rf_b)
  );

  // Newest value first: the instruction ahead, then the write made at the
  // edge this one read the RAM.
  function automatic logic [31:0] fwd(
    input logic [RIDX_W-1:0] idx,
    input logic [31:0]       ram,
    input logic              s2w,
    input logic [RIDX_W-1:0] s2rd,
    input logic [31:0]       s2v,
    input rvex_rf_wr_t       lw
  );
    logic [31:0] v;
    v = ram;
    if (s2w && s2rd == idx) begin
      v = s2v;
    end else if (lw.en && lw.idx == idx) begin
      v = lw.data;
    end
    return v;
  endfunction

  assign opa = fwd(s1_rs1, rf_a, s2_valid && s2_wr, s2_rd, s2_result, last_wr);
  assign opb = fwd(s1_rs2, rf_b, s2_valid && s2_wr, s2_rd, s2_result, last_wr);

  rvex_alu u_alu (
    .op(s1_op), .f3(s1_f3), .f7(s1_f7), .rd(s1_rd),
    .a(opa), .b(opb), .imm(s1_imm), .pc(s1_pc), .ex(ex)
  );

  always_comb begin
    mem_req.rd   = s1_adv && ex.mem_rd;
    mem_req.wr   = s1_adv && ex.mem_wr;
    mem_req.size = ex.size;
    mem_req.addr = ex.addr;
    mem_req.data = opb;
  end

  rvex_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk(clk), .rst(rst), .req(mem_req), .rdata(ld_word), .busy(busy)
  );

  always_comb begin
    s2_result = s2_val;
    if (s2_load) begin
      case (s2_f3)
        F3_B:    s2_result = {{24{ld_word[7]}}, ld_word[7:0]};
        F3_H:    s2_result = {{16{ld_word[15]}}, ld_word[15:0]};
        F3_BU:   s2_result = {24'd0, ld_word[7:0]};
        F3_HU:   s2_result = {16'd0, ld_word[15:0]};
        default: s2_result = ld_word;
      endcase
    end
    if (!s2_wr) begin
      s2_result = 32'd0;
    end
  end

  always_comb begin
    rf_wr.en   = s2_adv && s2_wr;
    rf_wr.idx  = s2_rd;
    rf_wr.data = s2_result;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
      last_wr.en   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      // hold the newest write; any later register file write replaces it
      if (rf_wr.en) begin
        last_wr <= rf_wr;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op  <= instr.op;
      s1_f3  <= instr.funct3;
      s1_f7  <= instr.funct7;
      s1_rs1 <= instr.src1_index;
      s1_rs2 <= instr.src2_index;
      s1_rd  <= instr.dest_index;
      s1_imm <= instr.immediate;
      s1_pc  <= instr.inst_pc;
    end
    if (s1_adv) begin
      s2_wr     <= ex.wr;
      s2_load   <= ex.mem_rd;
      s2_rd     <= s1_rd;
      s2_f3     <= s1_f3;
      s2_val    <= ex.val;
      s2_npc    <= ex.npc;
      s2_taken  <= ex.taken;
      s2_status <= ex.status;
    end
    if (s2_adv) begin
      result.next_pc      <= s2_npc;
      result.wrote_reg    <= s2_wr;
      result.write_value  <= s2_result;
      result.branch_taken <= s2_taken;
      result.status       <= s2_status;
    end
  end

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |-> rf_wr.idx != '0)
    else $error("register write targets x0");

  a_mem_one_op: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.rd && mem_req.wr))
    else $error("load and store issued in one cycle");

  a_bad_status_quiet: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_OK) |-> (!result.wrote_reg && !result.branch_taken))
    else $error("illegal instruction changed state");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !instr.ready)
    else $error("request taken before memory clear");

  a_rf_write_on_drain: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |=> result.valid && result.wrote_reg)
    else $error("register written without a result");

endmodule
`default_nettype wire

// ===== bench/tb_rv32i_execute_unit_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32i_execute_unit_top
// Self-checking bench for the RV32I execute unit. A short directed sequence
// hits the operand extremes, every opcode class, memory wrap-around and the
// rejected codes. Random instruction streams follow, with random idling on
// both channels. Each accepted request runs through a register file and
// memory model, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_rv32i_execute_unit_top;
  import rvex_pkg::*;

  localparam int MEM_BYTES    = 4096;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 150;

  // funct7 values that do not select the alternate operation
  localparam logic [6:0] F7_PLAIN = 7'h00;
  localparam logic [6:0] F7_OTHER = 7'h7F;
  // codes with no meaning for their opcode
  localparam logic [2:0] F3_LOAD_BAD   = 3'd3;
  localparam logic [2:0] F3_STORE_BAD  = 3'd5;
  localparam logic [2:0] F3_BRANCH_BAD = 3'd2;
  localparam logic [6:0] OP_UNKNOWN    = 7'h7F;

  localparam logic [2:0] LOAD_F3 [5] = '{F3_B, F3_H, F3_W, F3_BU, F3_HU};
  localparam logic [2:0] BRANCH_F3 [6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE,
                                           F3_BLTU, F3_BGEU};

  typedef struct packed {
    logic [6:0]  op;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [4:0]  dest_index;
    logic [31:0] immediate;
    logic [31:0] inst_pc;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wrote_reg;
    logic [31:0] write_value;
    logic        branch_taken;
    logic [1:0]  status;
  } result_t;

  class exec_scoreboard;
    logic [31:0] regs [NREGS];
    logic [7:0]  mem [MEM_BYTES];
    result_t     expected_results [$];
    int n_instr, n_checked, n_mem, n_taken, n_rejected, n_errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int unsigned byte_index(logic [31:0] addr, int k);
      logic [31:0] p;
      p = addr + k;
      return p % MEM_BYTES;
    endfunction

    function logic [31:0] alu(logic [2:0] f3, bit alt, bit is_r,
                              logic [31:0] a, logic [31:0] b);
      logic [4:0] sh;
      sh = b[4:0];
      case (f3)
        F3_ADD:  return (is_r && alt) ? a - b : a + b;
        F3_SLL:  return a << sh;
        F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
        F3_XOR:  return a ^ b;
        F3_SR: begin
          if (alt) return $signed(a) >>> sh;
          return a >> sh;
        end
        F3_OR:   return a | b;
        default: return a & b;
      endcase
    endfunction

    function result_t execute(instr_t it);
      logic [31:0] a, b, addr, val, npc, raw;
      logic [1:0]  st;
      bit          wr, taken, alt;
      int          nbytes;
      result_t     r;
      a     = regs[it.src1_index];
      b     = regs[it.src2_index];
      addr  = a + it.immediate;
      npc   = it.inst_pc + 32'd4;
      val   = '0;
      wr    = 1'b0;
      taken = 1'b0;
      st    = ST_OK;
      alt   = (it.funct7 == F7_ALT);
      case (it.op)
        OP_R: begin
          val = alu(it.funct3, alt, 1'b1, a, b);
          wr  = 1'b1;
        end
        OP_I: begin
          val = alu(it.funct3, alt, 1'b0, a, it.immediate);
          wr  = 1'b1;
        end
        OP_LOAD: begin
          for (int k = 0; k < 4; k++) raw[8*k +: 8] = mem[byte_index(addr, k)];
          case (it.funct3)
            F3_B:    val = {{24{raw[7]}}, raw[7:0]};
            F3_H:    val = {{16{raw[15]}}, raw[15:0]};
            F3_W:    val = raw;
            F3_BU:   val = {24'd0, raw[7:0]};
            F3_HU:   val = {16'd0, raw[15:0]};
            default: st = ST_BAD_F3;
          endcase
          wr = (st == ST_OK);
          n_mem++;
        end
        OP_STORE: begin
          if (it.funct3 inside {F3_B, F3_H, F3_W}) begin
            nbytes = (it.funct3 == F3_B) ? 1 : (it.funct3 == F3_H) ? 2 : 4;
            for (int k = 0; k < nbytes; k++) mem[byte_index(addr, k)] = b[8*k +: 8];
          end else begin
            st = ST_BAD_F3;
          end
          n_mem++;
        end
        OP_BRANCH: begin
          case (it.funct3)
            F3_BEQ:  taken = (a == b);
            F3_BNE:  taken = (a != b);
            F3_BLT:  taken = ($signed(a) < $signed(b));
            F3_BGE:  taken = !($signed(a) < $signed(b));
            F3_BLTU: taken = (a < b);
            F3_BGEU: taken = (a >= b);
            default: st = ST_BAD_F3;
          endcase
          if (taken) npc = it.inst_pc + it.immediate;
        end
        OP_JAL: begin
          val = it.inst_pc + 32'd4;
          wr  = 1'b1;
          npc = it.inst_pc + it.immediate;
        end
        OP_JALR: begin
          // target comes from the old rs1, even when rd is the same register
          npc = (a + it.immediate) & ~32'd1;
          val = it.inst_pc + 32'd4;
          wr  = 1'b1;
        end
        OP_LUI: begin
          val = it.immediate;
          wr  = 1'b1;
        end
        OP_AUIPC: begin
          val = it.inst_pc + it.immediate;
          wr  = 1'b1;
        end
        default: st = ST_BAD_OP;
      endcase
      if (wr && it.dest_index != 5'd0) begin
        regs[it.dest_index] = val;
      end else begin
        wr  = 1'b0;
        val = '0;
      end
      if (taken) n_taken++;
      if (st != ST_OK) n_rejected++;
      r.next_pc      = npc;
      r.wrote_reg    = wr;
      r.write_value  = val;
      r.branch_taken = taken;
      r.status       = st;
      return r;
    endfunction

    function void note_instr(instr_t it);
      expected_results.push_back(execute(it));
      n_instr++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: next_pc %h", got.next_pc);
        n_errors++;
        return;
      end
      want = expected_results.pop_front();
      n_checked++;
      if (got.next_pc !== want.next_pc) begin
        $error("next_pc: expected %h, actual %h", want.next_pc, got.next_pc);
        n_errors++;
      end
      if (got.wrote_reg !== want.wrote_reg) begin
        $error("wrote_reg: expected %b, actual %b", want.wrote_reg, got.wrote_reg);
        n_errors++;
      end
      if (got.write_value !== want.write_value) begin
        $error("write_value: expected %h, actual %h", want.write_value,
               got.write_value);
        n_errors++;
      end
      if (got.branch_taken !== want.branch_taken) begin
        $error("branch_taken: expected %b, actual %b", want.branch_taken,
               got.branch_taken);
        n_errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   burst;
  bit   hold_off_req;
  exec_scoreboard sb;

  rvex_in_if  instr_ch ();
  rvex_out_if result_ch ();

  rv32i_execute_unit_top #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial sb = new();

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // offsets around zero: low bytes and, wrapped, the top of memory
  function automatic logic [31:0] small_imm();
    return 32'(int'($urandom_range(0, 511)) - 256);
  endfunction

  function automatic instr_t make_instr(logic [6:0] op, logic [2:0] f3,
                                        logic [6:0] f7, logic [4:0] rs1,
                                        logic [4:0] rs2, logic [4:0] rd,
                                        logic [31:0] imm, logic [31:0] pc);
    instr_t it;
    it.op         = op;
    it.funct3     = f3;
    it.funct7     = f7;
    it.src1_index = rs1;
    it.src2_index = rs2;
    it.dest_index = rd;
    it.immediate  = imm;
    it.inst_pc    = pc;
    return it;
  endfunction

  function automatic instr_t random_instruction();
    instr_t      it;
    int unsigned pick;
    it.op         = OP_R;
    it.funct3     = 3'($urandom_range(0, 7));
    it.funct7     = $urandom_range(0, 1) ? F7_ALT : 7'($urandom_range(0, 127));
    it.src1_index = 5'($urandom_range(0, 31));
    it.src2_index = 5'($urandom_range(0, 31));
    it.dest_index = 5'($urandom_range(0, 31));
    it.immediate  = $urandom;
    it.inst_pc    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      it.op = OP_R;
    end else if (pick < 36) begin
      it.op = OP_I;
      if ($urandom_range(0, 1)) it.immediate = small_imm();
    end else if (pick < 68) begin
      it.op = (pick < 52) ? OP_LOAD : OP_STORE;
      // keep most accesses near address zero so loads see earlier stores
      if ($urandom_range(0, 2) != 0) begin
        it.src1_index = '0;
        it.immediate  = small_imm();
      end
      if ($urandom_range(0, 9) != 0) begin
        it.funct3 = (it.op == OP_LOAD) ? LOAD_F3[$urandom_range(0, 4)]
                                       : 3'($urandom_range(0, 2));
      end else if (it.op == OP_LOAD) begin
        do it.funct3 = 3'($urandom_range(0, 7));
        while (it.funct3 inside {F3_B, F3_H, F3_W, F3_BU, F3_HU});
      end else begin
        do it.funct3 = 3'($urandom_range(0, 7));
        while (it.funct3 inside {F3_B, F3_H, F3_W});
      end
    end else if (pick < 80) begin
      it.op = OP_BRANCH;
      if ($urandom_range(0, 4) == 0) it.src2_index = it.src1_index;
      if ($urandom_range(0, 1)) it.immediate = small_imm();
      if ($urandom_range(0, 9) != 0) begin
        it.funct3 = BRANCH_F3[$urandom_range(0, 5)];
      end else begin
        do it.funct3 = 3'($urandom_range(0, 7));
        while (it.funct3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU});
      end
    end else if (pick < 84) begin
      it.op = OP_JAL;
    end else if (pick < 88) begin
      it.op = OP_JALR;
    end else if (pick < 92) begin
      it.op = OP_LUI;
    end else if (pick < 95) begin
      it.op = OP_AUIPC;
    end else begin
      do it.op = 7'($urandom_range(0, 127));
      while (it.op inside {OP_R, OP_I, OP_LOAD, OP_STORE, OP_BRANCH, OP_JAL,
                           OP_JALR, OP_LUI, OP_AUIPC});
    end
    return it;
  endfunction

  task automatic issue(input instr_t it);
    int gap;
    instr_ch.valid      <= 1'b1;
    instr_ch.op         <= it.op;
    instr_ch.funct3     <= it.funct3;
    instr_ch.funct7     <= it.funct7;
    instr_ch.src1_index <= it.src1_index;
    instr_ch.src2_index <= it.src2_index;
    instr_ch.dest_index <= it.dest_index;
    instr_ch.immediate  <= it.immediate;
    instr_ch.inst_pc    <= it.inst_pc;
    @(posedge clk);
    while (instr_ch.ready !== 1'b1) @(posedge clk);
    sb.note_instr(it);
    @(negedge clk);
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    instr_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (!burst) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.next_pc      = result_ch.next_pc;
      got.wrote_reg    = result_ch.wrote_reg;
      got.write_value  = result_ch.write_value;
      got.branch_taken = result_ch.branch_taken;
      got.status       = result_ch.status;
      sb.check_result(got);
    end
  end

  // covers the memory clearing pass after reset and the slowest handshakes
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n;
    instr_ch.valid      <= 1'b0;
    instr_ch.op         <= '0;
    instr_ch.funct3     <= '0;
    instr_ch.funct7     <= '0;
    instr_ch.src1_index <= '0;
    instr_ch.src2_index <= '0;
    instr_ch.dest_index <= '0;
    instr_ch.immediate  <= '0;
    instr_ch.inst_pc    <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // operand extremes and the ALU corners
    issue(make_instr(OP_LUI, F3_ADD, F7_PLAIN, 0, 0, 1, 32'h8000_0000, 32'h0000_0000));
    issue(make_instr(OP_I, F3_ADD, F7_PLAIN, 0, 0, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFC));
    issue(make_instr(OP_I, F3_ADD, F7_PLAIN, 0, 0, 3, 32'h7FFF_FFFF, 32'h0000_0004));
    issue(make_instr(OP_R, F3_ADD, F7_PLAIN, 1, 2, 4, 32'h0, 32'h0000_0008));
    issue(make_instr(OP_R, F3_ADD, F7_ALT, 1, 3, 5, 32'h0, 32'h0000_000C));
    issue(make_instr(OP_R, F3_SR, F7_ALT, 1, 2, 6, 32'h0, 32'h0000_0010));
    issue(make_instr(OP_R, F3_SR, F7_OTHER, 1, 2, 7, 32'h0, 32'h0000_0014));
    issue(make_instr(OP_I, F3_SLL, F7_ALT, 2, 0, 8, 32'h0000_0025, 32'h0000_0018));
    issue(make_instr(OP_I, F3_ADD, F7_ALT, 3, 0, 9, 32'h0000_0001, 32'h0000_001C));
    issue(make_instr(OP_R, F3_SLT, F7_PLAIN, 1, 3, 10, 32'h0, 32'h0000_0020));
    issue(make_instr(OP_R, F3_SLTU, F7_PLAIN, 1, 3, 0, 32'h0, 32'h0000_0024));
    // word store straddling the top of memory, then loads back across the wrap
    issue(make_instr(OP_LUI, F3_ADD, F7_PLAIN, 0, 0, 12, 32'h8765_4321, 32'h0000_0028));
    issue(make_instr(OP_STORE, F3_W, F7_PLAIN, 0, 12, 0, 32'hFFFF_FFFE, 32'h0000_002C));
    issue(make_instr(OP_LOAD, F3_W, F7_PLAIN, 0, 0, 13, 32'hFFFF_FFFE, 32'h0000_0030));
    issue(make_instr(OP_LOAD, F3_B, F7_PLAIN, 0, 0, 14, 32'h0000_0001, 32'h0000_0034));
    issue(make_instr(OP_LOAD, F3_HU, F7_PLAIN, 0, 0, 15, 32'h0000_0000, 32'h0000_0038));
    // branches, jumps and pc-relative writes
    issue(make_instr(OP_BRANCH, F3_BEQ, F7_PLAIN, 0, 0, 0, 32'hFFFF_FFF8, 32'h0000_0100));
    issue(make_instr(OP_BRANCH, F3_BLT, F7_PLAIN, 1, 3, 0, 32'h0000_0040, 32'h0000_0104));
    issue(make_instr(OP_BRANCH, F3_BGEU, F7_PLAIN, 1, 3, 0, 32'h8000_0000, 32'h0000_0108));
    issue(make_instr(OP_JAL, F3_ADD, F7_PLAIN, 0, 0, 16, 32'h0000_0007, 32'h0000_0200));
    issue(make_instr(OP_JALR, F3_ADD, F7_PLAIN, 3, 0, 17, 32'h0, 32'h0000_0204));
    issue(make_instr(OP_JALR, F3_ADD, F7_PLAIN, 17, 0, 17, 32'h0000_0001, 32'h0000_0208));
    issue(make_instr(OP_AUIPC, F3_ADD, F7_PLAIN, 0, 0, 18, 32'h8000_0000, 32'h8000_0000));
    // rejected codes must leave every register alone
    issue(make_instr(OP_LOAD, F3_LOAD_BAD, F7_PLAIN, 0, 0, 19, 32'h0, 32'h0000_0300));
    issue(make_instr(OP_STORE, F3_STORE_BAD, F7_PLAIN, 0, 2, 0, 32'h0, 32'h0000_0304));
    issue(make_instr(OP_BRANCH, F3_BRANCH_BAD, F7_PLAIN, 0, 0, 0, 32'h0000_0100,
                     32'h0000_0308));
    issue(make_instr(OP_UNKNOWN, F3_ADD, F7_PLAIN, 1, 2, 20, 32'h0, 32'h0000_030C));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 150) hold_off_req = 1'b1;
      if (n == 350) wait_drained();
      issue(random_instruction());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d instructions: %0d loads/stores, %0d taken branches, %0d rejected.",
             sb.n_instr, sb.n_mem, sb.n_taken, sb.n_rejected);
    $display("Compared %0d results field by field, %0d mismatches.",
             sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
